/* sv/keyed_record_table_assert.svh */
// Assertion macros used by the port checker of the keyed record table.
`ifndef KEYED_RECORD_TABLE_ASSERT_SVH
`define KEYED_RECORD_TABLE_ASSERT_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define KRT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Asserts that an antecedent implies a consequent in the next cycle.
`define KRT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/krt_pkg.sv */
// Package with the types, codes and constants of the keyed record table.
package krt_pkg;
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 64;
    localparam int OP_W      = 3;
    localparam int POS_W     = 6;
    localparam int COUNT_W   = 7;
    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_FRONT  = 3'd1,
        OP_SORTED = 3'd2,
        OP_DELETE = 3'd3,
        OP_FIND   = 3'd4,
        OP_CLEAR  = 3'd5,
        OP_SORT   = 3'd6,
        OP_NONE   = 3'd7
    } op_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // Datapath commands from the controller.
    typedef struct packed {
        logic rd;
        logic wr;
        logic wr_src_new;   // write the new record instead of the write data
    } dp_cmd_t;
endpackage

/* sv/krt_datapath.sv */
// Record memory of the keyed record table with one write and one read port.
module krt_datapath #(
    parameter int DEPTH = krt_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  krt_pkg::dp_cmd_t            cmd,
    input  logic [IDX_W-1:0]            rd_idx,
    input  logic [IDX_W-1:0]            wr_idx,
    input  logic [krt_pkg::KEY_W-1:0]   new_key,
    input  logic [krt_pkg::PAYLOAD_W-1:0] new_payload,
    input  logic [krt_pkg::KEY_W-1:0]   wr_key,
    input  logic [krt_pkg::PAYLOAD_W-1:0] wr_payload,
    output logic [krt_pkg::KEY_W-1:0]   rd_key,
    output logic [krt_pkg::PAYLOAD_W-1:0] rd_payload
);
    import krt_pkg::*;

    logic [KEY_W-1:0]     key_mem [DEPTH];
    logic [PAYLOAD_W-1:0] pay_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            key_mem[wr_idx] <= cmd.wr_src_new ? new_key : wr_key;
            pay_mem[wr_idx] <= cmd.wr_src_new ? new_payload : wr_payload;
        end
        if (cmd.rd) begin
            rd_key     <= key_mem[rd_idx];
            rd_payload <= pay_mem[rd_idx];
        end
    end
endmodule

/* sv/krt_ctrl.sv */
// Controller of the keyed record table: operation sequencer and counters.
module krt_ctrl #(
    parameter int DEPTH = krt_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [krt_pkg::OP_W-1:0]      in_op,
    input  logic [krt_pkg::KEY_W-1:0]     in_key,
    input  logic [krt_pkg::PAYLOAD_W-1:0] in_payload,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    out_status,
    output logic [krt_pkg::POS_W-1:0]     out_pos,
    output logic [krt_pkg::COUNT_W-1:0]   out_count,
    output krt_pkg::dp_cmd_t              cmd,
    output logic [IDX_W-1:0]              rd_idx,
    output logic [IDX_W-1:0]              wr_idx,
    output logic [krt_pkg::KEY_W-1:0]     new_key,
    output logic [krt_pkg::PAYLOAD_W-1:0] new_payload,
    output logic [krt_pkg::KEY_W-1:0]     wr_key,
    output logic [krt_pkg::PAYLOAD_W-1:0] wr_payload,
    input  logic [krt_pkg::KEY_W-1:0]     rd_key,
    input  logic [krt_pkg::PAYLOAD_W-1:0] rd_payload
);
    import krt_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_DISPATCH  = 14'b00000000000010,
        S_SCAN_RD   = 14'b00000000000100,
        S_SCAN_CK   = 14'b00000000001000,
        S_SHUP_INIT = 14'b00000000010000,
        S_SHUP      = 14'b00000000100000,
        S_PUT       = 14'b00000001000000,
        S_SHDN_INIT = 14'b00000010000000,
        S_SHDN      = 14'b00000100000000,
        S_SORT_INIT = 14'b00001000000000,
        S_SORT_LOAD = 14'b00010000000000,
        S_SORT_CMP  = 14'b00100000000000,
        S_SORT_END  = 14'b01000000000000,
        S_DONE      = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;       // walking index
    logic [CNT_W-1:0] lim_reg, lim_next;   // last index of the bubble pass
    logic             swp_reg, swp_next;   // swap seen in this pass
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [1:0]       status_reg, status_next;
    op_t              op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, hk_reg, hk_next;
    logic [PAYLOAD_W-1:0] pay_reg, hp_reg, hp_next;
    logic             ovalid_reg, ovalid_next;
    logic [1:0]       ost_reg;
    logic [POS_W-1:0] opos_reg;
    logic [COUNT_W-1:0] ocnt_reg;
    logic             wr_from_held;
    logic             load_out;
    logic [KEY_W-1:0] cmp_ref;
    logic             key_lt, key_eq;

    assign cmp_ref = (state_reg == S_SORT_CMP) ? hk_reg : key_reg;

    krt_ctrl_fix u_cmp (
        .a(rd_key), .b(cmp_ref), .lt(key_lt), .eq(key_eq)
    );

    assign new_key     = key_reg;
    assign new_payload = pay_reg;
    assign wr_key      = wr_from_held ? hk_reg : rd_key;
    assign wr_payload  = wr_from_held ? hp_reg : rd_payload;
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = ovalid_reg;
    assign out_status  = ost_reg;
    assign out_pos     = opos_reg;
    assign out_count   = ocnt_reg;

    // The key walk compares the entry that was read in the cycle before. The
    // bubble pass carries the larger entry in the held register and writes
    // the smaller one back.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        i_next       = i_reg;
        lim_next     = lim_reg;
        swp_next     = swp_reg;
        pos_next     = pos_reg;
        status_next  = status_reg;
        op_next      = op_reg;
        hk_next      = hk_reg;
        hp_next      = hp_reg;
        cmd          = '0;
        rd_idx       = i_reg[IDX_W-1:0];
        wr_idx       = i_reg[IDX_W-1:0];
        wr_from_held = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next     = op_t'(in_op);
                    status_next = ST_OK;
                    pos_next    = '0;
                    i_next      = '0;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (op_reg) inside
                    OP_APPEND, OP_FRONT, OP_SORTED: begin
                        if (count_reg == CNT_W'(DEPTH)) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else if (op_reg == OP_APPEND) begin
                            pos_next   = count_reg;
                            state_next = S_PUT;
                        end else if (op_reg == OP_FRONT) begin
                            state_next = S_SHUP_INIT;
                        end else if (count_reg > CNT_W'(1)) begin
                            lim_next   = count_reg - CNT_W'(1);
                            swp_next   = 1'b0;
                            state_next = S_SORT_INIT;
                        end else begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    OP_DELETE, OP_FIND: state_next = S_SCAN_RD;
                    OP_CLEAR: begin
                        count_next = '0;
                        state_next = S_DONE;
                    end
                    OP_SORT: begin
                        if (count_reg > CNT_W'(1)) begin
                            lim_next   = count_reg - CNT_W'(1);
                            swp_next   = 1'b0;
                            state_next = S_SORT_INIT;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_SCAN_RD: begin
                if (i_reg >= count_reg) begin
                    if (op_reg == OP_SORTED) begin
                        pos_next   = count_reg;
                        state_next = S_SHUP_INIT;
                    end else begin
                        status_next = ST_MISSING;
                        state_next  = S_DONE;
                    end
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = S_SCAN_CK;
                end
            end
            S_SCAN_CK: begin
                if ((op_reg == OP_SORTED) ? !key_lt : key_eq) begin
                    pos_next = i_reg;
                    if (op_reg == OP_FIND) begin
                        state_next = S_DONE;
                    end else if (op_reg == OP_DELETE) begin
                        state_next = S_SHDN_INIT;
                    end else begin
                        state_next = S_SHUP_INIT;
                    end
                end else begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            // Shift up: entry i-1 moves to i, from the top down to the slot.
            S_SHUP_INIT: begin
                if (count_reg == pos_reg) begin
                    state_next = S_PUT;
                end else begin
                    rd_idx     = IDX_W'(count_reg - CNT_W'(1));
                    cmd.rd     = 1'b1;
                    i_next     = count_reg;
                    state_next = S_SHUP;
                end
            end
            S_SHUP: begin
                cmd.wr = 1'b1;
                if ((i_reg - CNT_W'(1)) == pos_reg) begin
                    state_next = S_PUT;
                end else begin
                    rd_idx = IDX_W'(i_reg - CNT_W'(2));
                    cmd.rd = 1'b1;
                    i_next = i_reg - CNT_W'(1);
                end
            end
            S_PUT: begin
                cmd.wr         = 1'b1;
                cmd.wr_src_new = 1'b1;
                wr_idx         = pos_reg[IDX_W-1:0];
                count_next     = count_reg + CNT_W'(1);
                state_next     = S_DONE;
            end
            // Shift down: entry i+1 moves to i, from the removed slot up.
            S_SHDN_INIT: begin
                if ((pos_reg + CNT_W'(1)) >= count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end else begin
                    rd_idx     = IDX_W'(pos_reg + CNT_W'(1));
                    cmd.rd     = 1'b1;
                    i_next     = pos_reg;
                    state_next = S_SHDN;
                end
            end
            S_SHDN: begin
                cmd.wr = 1'b1;
                if ((i_reg + CNT_W'(2)) >= count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end else begin
                    rd_idx = IDX_W'(i_reg + CNT_W'(2));
                    cmd.rd = 1'b1;
                    i_next = i_reg + CNT_W'(1);
                end
            end
            S_SORT_INIT: begin
                rd_idx     = '0;
                cmd.rd     = 1'b1;
                i_next     = '0;
                state_next = S_SORT_LOAD;
            end
            S_SORT_LOAD: begin
                hk_next    = rd_key;
                hp_next    = rd_payload;
                rd_idx     = IDX_W'(i_reg + CNT_W'(1));
                cmd.rd     = 1'b1;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                cmd.wr = 1'b1;
                if (key_lt) begin
                    swp_next = 1'b1;
                end else begin
                    wr_from_held = 1'b1;
                    hk_next      = rd_key;
                    hp_next      = rd_payload;
                end
                if ((i_reg + CNT_W'(1)) == lim_reg) begin
                    state_next = S_SORT_END;
                end else begin
                    rd_idx = IDX_W'(i_reg + CNT_W'(2));
                    cmd.rd = 1'b1;
                    i_next = i_reg + CNT_W'(1);
                end
            end
            S_SORT_END: begin
                cmd.wr       = 1'b1;
                wr_from_held = 1'b1;
                wr_idx       = lim_reg[IDX_W-1:0];
                if (!swp_reg || lim_reg == CNT_W'(1)) begin
                    i_next     = '0;
                    state_next = (op_reg == OP_SORTED) ? S_SCAN_RD : S_DONE;
                end else begin
                    lim_next   = lim_reg - CNT_W'(1);
                    swp_next   = 1'b0;
                    state_next = S_SORT_INIT;
                end
            end
            S_DONE: begin
                if (!ovalid_reg || out_ready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign ovalid_next = load_out | (ovalid_reg & ~out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        lim_reg    <= lim_next;
        swp_reg    <= swp_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        op_reg     <= op_next;
        hk_reg     <= hk_next;
        hp_reg     <= hp_next;
        if (state_reg == S_IDLE && in_valid) begin
            key_reg <= in_key;
            pay_reg <= in_payload;
        end
        if (load_out) begin
            ost_reg  <= status_reg;
            opos_reg <= POS_W'(pos_reg);
            ocnt_reg <= COUNT_W'(count_reg);
        end
    end
endmodule

/* sv/krt_ctrl_fix.sv */
// Unsigned key comparator shared by the table walks of the controller.
module krt_ctrl_fix (
    input  logic [krt_pkg::KEY_W-1:0] a,
    input  logic [krt_pkg::KEY_W-1:0] b,
    output logic                      lt,
    output logic                      eq
);
    assign lt = (a < b);
    assign eq = (a == b);
endmodule

/* sv/keyed_record_table.sv */
// Top level of the keyed record table.
//  channel | dir | fields (tdata, lowest bit first)
//  s_      | in  | operation[2:0] key[34:3] payload[98:35]
//  m_      | out | status[1:0] position[7:2] entry_count[14:8]
// One word at a time; an append goes through dispatch, put and done before
// the next accept. Find and delete scan each entry with a read and a check
// state, a shift moves one entry per cycle after a setup state, and a sort
// makes up to DEPTH - 1 bubble passes over a shrinking range: it is quadratic.
// Reset is synchronous and clears the count and control; stores keep data.
// A stalled result holds; the next word is taken once the result is loaded.
module keyed_record_table #(
    parameter int DEPTH = krt_pkg::DEPTH_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // operation, key, payload
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata    // status, position, entry_count
);
    import krt_pkg::*;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dp_cmd_t cmd;
    logic [IDX_W-1:0] rd_idx, wr_idx;
    logic [KEY_W-1:0] new_key, wr_key, rd_key;
    logic [PAYLOAD_W-1:0] new_payload, wr_payload, rd_payload;
    logic [1:0] st;
    logic [POS_W-1:0] pos;
    logic [COUNT_W-1:0] cnt;

    krt_ctrl #(.DEPTH(DEPTH), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(s_tdata[2:0]), .in_key(s_tdata[34:3]), .in_payload(s_tdata[98:35]),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_status(st), .out_pos(pos), .out_count(cnt),
        .cmd, .rd_idx, .wr_idx, .new_key, .new_payload, .wr_key, .wr_payload,
        .rd_key, .rd_payload
    );

    krt_datapath #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_dp (
        .aclk, .cmd, .rd_idx, .wr_idx, .new_key, .new_payload,
        .wr_key, .wr_payload, .rd_key, .rd_payload
    );

    assign m_tdata = {1'b0, cnt, pos, st};
endmodule

/* sv/keyed_record_table_checker.sv */
// Port checker of the keyed record table, bound to the top level.
`include "keyed_record_table_assert.svh"
module keyed_record_table_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [15:0]  m_tdata
);
    `KRT_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `KRT_ASSERT_IMPL(a_status, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3)
    `KRT_ASSERT_IMPL(a_count, aclk, aresetn, m_tvalid, m_tdata[14:8] <= 7'd64)
    `KRT_ASSERT_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

bind keyed_record_table keyed_record_table_checker u_chk (.*);
